### design/glob_or_substring_name_matcher_defines.svh
// Assertion macros for the name matcher.
`ifndef GLOB_OR_SUBSTRING_NAME_MATCHER_DEFINES_SVH
`define GLOB_OR_SUBSTRING_NAME_MATCHER_DEFINES_SVH
`ifndef SYNTHESIS
// Consequence holds in the same cycle as the antecedent.
`define GOSM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gosm assertion failed");
// Consequence holds in the cycle after the antecedent.
`define GOSM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gosm assertion failed");
`else
`define GOSM_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define GOSM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### design/gosm_pkg.sv
package gosm_pkg;

   // Special pattern bytes
   localparam logic [7:0] STAR       = 8'h2A;
   localparam logic [7:0] QMARK      = 8'h3F;
   localparam logic [7:0] LBRACK     = 8'h5B;
   localparam logic [7:0] RBRACK     = 8'h5D;
   localparam logic [7:0] BANG       = 8'h21;
   localparam logic [7:0] DASH       = 8'h2D;
   localparam logic [7:0] UPPER_A    = 8'h41;
   localparam logic [7:0] UPPER_Z    = 8'h5A;
   localparam logic [7:0] FOLD_DELTA = 8'd32;

   // Register indexes
   localparam logic CSR_FOLD_MODE  = 1'b0;
   localparam logic CSR_WHOLE_NAME = 1'b1;

   // Folding modes
   localparam logic [1:0] FOLD_NEVER  = 2'd0;
   localparam logic [1:0] FOLD_ALWAYS = 2'd1;

   // Result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NAME_BIG = 2'd1;
   localparam logic [1:0] STATUS_PAT_BIG  = 2'd2;

   typedef struct packed {
      logic       action;
      logic [7:0] char_byte;
      logic       last;
      logic       empty_req;
   } req_word_type;

   typedef struct packed {
      logic       matched;
      logic [1:0] status;
   } rsp_word_type;

   // One step of a bracket class scan
   typedef struct packed {
      logic at_end;
      logic close_br;
      logic is_range;
      logic elem_hit;
   } cls_step_type;

   // Map A-Z to a-z when folding is on
   function automatic logic [7:0] fold_byte(input logic on, input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (on && c >= UPPER_A && c <= UPPER_Z) begin
         r = c + FOLD_DELTA;
      end
      return r;
   endfunction

   function automatic logic is_meta(input logic [7:0] c);
      return (c == STAR) || (c == QMARK) || (c == LBRACK);
   endfunction

endpackage

### design/gosm_class_eval.sv
module gosm_class_eval #(
   parameter int PW = 7
) (
   input  logic                  fold_on,
   input  logic [7:0]            name_byte,
   input  logic [7:0]            b0,
   input  logic [7:0]            b1,
   input  logic [7:0]            b2,
   input  logic [PW-1:0]         q,
   input  logic [PW-1:0]         plen,
   output gosm_pkg::cls_step_type step
);

   logic [PW:0] q2;
   logic [7:0]  fc;
   logic        in0;

   // Evaluate one class element at q against the held name byte
   always_comb begin
      q2            = {1'b0, q} + (PW+1)'(2);
      fc            = gosm_pkg::fold_byte(fold_on, name_byte);
      in0           = q < plen;
      step.at_end   = !(in0 && b0 != gosm_pkg::RBRACK);
      step.close_br = in0 && b0 == gosm_pkg::RBRACK;
      step.is_range = (q2 < {1'b0, plen}) && b1 == gosm_pkg::DASH && b2 != gosm_pkg::RBRACK;
      if (step.is_range) begin
         step.elem_hit = fc >= gosm_pkg::fold_byte(fold_on, b0) &&
                         fc <= gosm_pkg::fold_byte(fold_on, b2);
      end else begin
         step.elem_hit = fc == gosm_pkg::fold_byte(fold_on, b0);
      end
   end

endmodule

### design/glob_or_substring_name_matcher.sv
// Pattern-against-name matcher.
// req channel: one word per pattern byte (action 0) or name byte (action 1);
// last or empty_req closes the string. Bytes are written to on-chip memories
// at one word per cycle while the block is idle.
// rsp channel: one word (matched, status) per closed name, nothing otherwise.
// csr channel: index 0 folding mode, index 1 exact-compare flag; always ready.
// Walk: a closing name word starts a walk over the two memories. A glob
// whose tail after its last '*' holds no meta byte first compares that tail
// byte by byte. Each literal or '?' step passes ST_STEP and ST_EVAL, each
// class element ST_CRD0, ST_CRD1, ST_CRD2 and ST_CEVAL, each backtrack goes
// back to ST_STEP; ST_START opens the walk and ST_DONE delivers the result.
// The walk reads one pattern byte and one name byte per step through the
// single read port of each memory, which sets the rate.
// req_stall is high while a walk runs; pattern and non-closing name words
// are taken every cycle otherwise, also while a result waits on rsp.
// A stalled rsp word holds; the walk result waits in its own state.
// Reset clears counts, flags, control registers and both channels; payload
// registers and memories need no clearing; only entries below counts matter.
`include "glob_or_substring_name_matcher_defines.svh"

module glob_or_substring_name_matcher #(
   parameter int PATTERN_MAX = 64,
   parameter int NAME_MAX    = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  gosm_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output gosm_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [1:0]             csr_wdata
);

   localparam int PW = $clog2(PATTERN_MAX + 1);
   localparam int PA = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int NW = $clog2(NAME_MAX + 1);
   localparam int NA = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
   localparam int CW = (PW > NW) ? PW : NW;

   typedef enum logic [14:0] {
      ST_IDLE  = 15'b000000000000001,
      ST_START = 15'b000000000000010,
      ST_STEP  = 15'b000000000000100,
      ST_EVAL  = 15'b000000000001000,
      ST_CNRD  = 15'b000000000010000,
      ST_CNEG  = 15'b000000000100000,
      ST_CRD0  = 15'b000000001000000,
      ST_CRD1  = 15'b000000010000000,
      ST_CRD2  = 15'b000000100000000,
      ST_CEVAL = 15'b000001000000000,
      ST_TRD   = 15'b000010000000000,
      ST_TEV   = 15'b000100000000000,
      ST_DONE  = 15'b001000000000000,
      ST_SRD   = 15'b010000000000000,
      ST_SCMP  = 15'b100000000000000
   } state_type;

   // Memories
   logic [7:0] pmem [PATTERN_MAX];
   logic [7:0] nmem [NAME_MAX];

   // Control registers
   state_type   state_ff, state_in;
   logic [PW-1:0] pcount_ff, pcount_in;
   logic        pov_ff, pov_in;
   logic        pclosed_ff, pclosed_in;
   logic        cap_ff, cap_in;
   logic        meta_ff, meta_in;
   logic [PW-1:0] lstar_ff, lstar_in;
   logic        sstar_ff, sstar_in;
   logic        smeta_ff, smeta_in;
   logic [NW-1:0] ncount_ff, ncount_in;
   logic        nov_ff, nov_in;
   logic [1:0]  fold_mode_ff, fold_mode_in;
   logic        whole_ff, whole_in;
   logic        fold_ff, fold_in;
   logic        substr_ff, substr_in;
   logic        have_star_ff, have_star_in;
   logic [PW-1:0] pi_ff, pi_in;
   logic [PW-1:0] star_next_ff, star_next_in;
   logic [PW-1:0] q_ff, q_in;
   logic [NW-1:0] ni_ff, ni_in;
   logic [NW-1:0] retry_ff, retry_in;
   logic        neg_ff, neg_in;
   logic        ok_ff, ok_in;
   logic        res_m_ff, res_m_in;
   logic [1:0]  res_s_ff, res_s_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [7:0]  p_rd_ff, n_rd_ff;
   logic [7:0]  nb_ff, nb_in;
   logic [7:0]  b0_ff, b0_in;
   logic [7:0]  b1_ff, b1_in;
   gosm_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   // Memory ports and helpers
   logic          p_we, n_we;
   logic [PA-1:0] p_waddr, p_raddr;
   logic [NA-1:0] n_waddr, n_raddr;
   logic          req_acc;
   logic          close;
   logic [PW-1:0] p_base;
   logic          pin;
   logic [CW-1:0] sfx_len;
   gosm_pkg::cls_step_type cls;

   assign csr_ready = 1'b1;
   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign req_acc   = req_valid && !req_stall;
   assign close     = req_word.last || req_word.empty_req;
   assign pin       = pi_ff < pcount_ff;
   assign sfx_len   = CW'(pcount_ff) - CW'(lstar_ff) - CW'(1);

   gosm_class_eval #(
      .PW (PW)
   ) u_cls (
      .fold_on   (fold_ff),
      .name_byte (nb_ff),
      .b0        (b0_ff),
      .b1        (b1_ff),
      .b2        (p_rd_ff),
      .q         (q_ff),
      .plen      (pcount_ff),
      .step      (cls)
   );

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      pcount_in     = pcount_ff;
      pov_in        = pov_ff;
      pclosed_in    = pclosed_ff;
      cap_in        = cap_ff;
      meta_in       = meta_ff;
      lstar_in      = lstar_ff;
      sstar_in      = sstar_ff;
      smeta_in      = smeta_ff;
      ncount_in     = ncount_ff;
      nov_in        = nov_ff;
      fold_mode_in  = fold_mode_ff;
      whole_in      = whole_ff;
      fold_in       = fold_ff;
      substr_in     = substr_ff;
      have_star_in  = have_star_ff;
      pi_in         = pi_ff;
      star_next_in  = star_next_ff;
      q_in          = q_ff;
      ni_in         = ni_ff;
      retry_in      = retry_ff;
      neg_in        = neg_ff;
      ok_in         = ok_ff;
      res_m_in      = res_m_ff;
      res_s_in      = res_s_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      nb_in         = nb_ff;
      b0_in         = b0_ff;
      b1_in         = b1_ff;
      p_we          = 1'b0;
      n_we          = 1'b0;
      p_base        = pclosed_ff ? '0 : pcount_ff;
      p_waddr       = PA'(p_base);
      n_waddr       = NA'(ncount_ff);
      p_raddr       = PA'(pi_ff);
      n_raddr       = NA'(ni_ff);

      // Take configuration writes
      if (csr_valid) begin
         unique case (csr_index)
            gosm_pkg::CSR_FOLD_MODE:  fold_mode_in = csr_wdata;
            gosm_pkg::CSR_WHOLE_NAME: whole_in     = csr_wdata[0];
            default: ;
         endcase
      end

      // Drop the output word once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && !req_word.action) begin
               // Append a pattern byte, restarting after a closed pattern
               pcount_in  = p_base;
               if (pclosed_ff) begin
                  pov_in   = 1'b0;
                  cap_in   = 1'b0;
                  meta_in  = 1'b0;
                  sstar_in = 1'b0;
                  smeta_in = 1'b0;
               end
               if (!req_word.empty_req) begin
                  if (p_base < PW'(PATTERN_MAX)) begin
                     p_we      = 1'b1;
                     pcount_in = p_base + PW'(1);
                     if (req_word.char_byte >= gosm_pkg::UPPER_A &&
                         req_word.char_byte <= gosm_pkg::UPPER_Z) begin
                        cap_in = 1'b1;
                     end
                     if (gosm_pkg::is_meta(req_word.char_byte)) begin
                        meta_in = 1'b1;
                     end
                     // Track the last star and any meta byte after it
                     if (req_word.char_byte == gosm_pkg::STAR) begin
                        lstar_in = p_base;
                        sstar_in = 1'b1;
                        smeta_in = 1'b0;
                     end else if (gosm_pkg::is_meta(req_word.char_byte)) begin
                        smeta_in = 1'b1;
                     end
                  end else begin
                     pov_in = 1'b1;
                  end
               end
               pclosed_in = close;
            end else if (req_acc) begin
               // Append a name byte; a closing word starts the walk
               if (!req_word.empty_req) begin
                  if (ncount_ff < NW'(NAME_MAX)) begin
                     n_we      = 1'b1;
                     ncount_in = ncount_ff + NW'(1);
                  end else begin
                     nov_in = 1'b1;
                  end
               end
               if (close) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            pi_in        = '0;
            ni_in        = '0;
            retry_in     = '0;
            star_next_in = '0;
            substr_in    = !meta_ff && !whole_ff;
            have_star_in = !meta_ff && !whole_ff;
            if (fold_mode_ff == gosm_pkg::FOLD_NEVER) begin
               fold_in = 1'b0;
            end else if (fold_mode_ff == gosm_pkg::FOLD_ALWAYS) begin
               fold_in = 1'b1;
            end else begin
               fold_in = !cap_ff;
            end
            priority if (pov_ff) begin
               res_m_in = 1'b0;
               res_s_in = gosm_pkg::STATUS_PAT_BIG;
               state_in = ST_DONE;
            end else if (nov_ff) begin
               res_m_in = 1'b0;
               res_s_in = gosm_pkg::STATUS_NAME_BIG;
               state_in = ST_DONE;
            end else if (pcount_ff == '0) begin
               res_m_in = 1'b1;
               res_s_in = gosm_pkg::STATUS_OK;
               state_in = ST_DONE;
            end else if (meta_ff && sstar_ff && !smeta_ff && sfx_len != '0) begin
               // Compare the literal tail after the last star first
               res_s_in = gosm_pkg::STATUS_OK;
               if (CW'(ncount_ff) < sfx_len) begin
                  res_m_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  q_in     = lstar_ff + PW'(1);
                  ni_in    = NW'(CW'(ncount_ff) - sfx_len);
                  state_in = ST_SRD;
               end
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_SRD: begin
            p_raddr  = PA'(q_ff);
            state_in = ST_SCMP;
         end
         ST_SCMP: begin
            if (gosm_pkg::fold_byte(fold_ff, p_rd_ff) !=
                gosm_pkg::fold_byte(fold_ff, n_rd_ff)) begin
               res_m_in = 1'b0;
               state_in = ST_DONE;
            end else if (q_ff + PW'(1) == pcount_ff) begin
               pi_in    = '0;
               ni_in    = '0;
               state_in = ST_STEP;
            end else begin
               q_in     = q_ff + PW'(1);
               ni_in    = ni_ff + NW'(1);
               state_in = ST_SRD;
            end
         end
         ST_STEP: begin
            // Read pattern at pi and name at ni
            res_s_in = gosm_pkg::STATUS_OK;
            priority if (substr_ff && pi_ff == pcount_ff) begin
               res_m_in = 1'b1;
               state_in = ST_DONE;
            end else if (ni_ff == ncount_ff) begin
               state_in = ST_TRD;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            nb_in = n_rd_ff;
            priority if (pin && p_rd_ff == gosm_pkg::QMARK) begin
               pi_in    = pi_ff + PW'(1);
               ni_in    = ni_ff + NW'(1);
               state_in = ST_STEP;
            end else if (pin && p_rd_ff == gosm_pkg::LBRACK) begin
               q_in     = pi_ff + PW'(1);
               neg_in   = 1'b0;
               ok_in    = 1'b0;
               state_in = ST_CNRD;
            end else if (pin && p_rd_ff != gosm_pkg::STAR &&
                         gosm_pkg::fold_byte(fold_ff, p_rd_ff) ==
                         gosm_pkg::fold_byte(fold_ff, n_rd_ff)) begin
               pi_in    = pi_ff + PW'(1);
               ni_in    = ni_ff + NW'(1);
               state_in = ST_STEP;
            end else if (pin && p_rd_ff == gosm_pkg::STAR) begin
               star_next_in = pi_ff + PW'(1);
               have_star_in = 1'b1;
               pi_in        = pi_ff + PW'(1);
               retry_in     = ni_ff;
               state_in     = ST_STEP;
            end else if (have_star_ff) begin
               // Backtrack to the most recent star
               pi_in    = star_next_ff;
               retry_in = retry_ff + NW'(1);
               ni_in    = retry_ff + NW'(1);
               state_in = ST_STEP;
            end else begin
               res_m_in = 1'b0;
               state_in = ST_DONE;
            end
         end
         ST_CNRD: begin
            p_raddr  = PA'(q_ff);
            state_in = ST_CNEG;
         end
         ST_CNEG: begin
            if (q_ff < pcount_ff && p_rd_ff == gosm_pkg::BANG) begin
               neg_in = 1'b1;
               q_in   = q_ff + PW'(1);
            end
            state_in = ST_CRD0;
         end
         ST_CRD0: begin
            p_raddr  = PA'(q_ff);
            state_in = ST_CRD1;
         end
         ST_CRD1: begin
            p_raddr  = PA'({1'b0, q_ff} + (PW+1)'(1));
            b0_in    = p_rd_ff;
            state_in = ST_CRD2;
         end
         ST_CRD2: begin
            p_raddr  = PA'({1'b0, q_ff} + (PW+1)'(2));
            b1_in    = p_rd_ff;
            state_in = ST_CEVAL;
         end
         ST_CEVAL: begin
            if (!cls.at_end) begin
               // Advance past one element
               ok_in    = ok_ff || cls.elem_hit;
               q_in     = cls.is_range ? q_ff + PW'(3) : q_ff + PW'(1);
               state_in = ST_CRD0;
            end else if (neg_ff ^ ok_ff) begin
               pi_in    = cls.close_br ? q_ff + PW'(1) : q_ff;
               ni_in    = ni_ff + NW'(1);
               state_in = ST_STEP;
            end else if (have_star_ff) begin
               pi_in    = star_next_ff;
               retry_in = retry_ff + NW'(1);
               ni_in    = retry_ff + NW'(1);
               state_in = ST_STEP;
            end else begin
               res_m_in = 1'b0;
               state_in = ST_DONE;
            end
         end
         ST_TRD: begin
            // Skip trailing stars
            if (pin) begin
               state_in = ST_TEV;
            end else begin
               res_m_in = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_TEV: begin
            if (p_rd_ff == gosm_pkg::STAR) begin
               pi_in    = pi_ff + PW'(1);
               state_in = ST_TRD;
            end else begin
               res_m_in = 1'b0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the output register frees
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_word_in.matched = res_m_ff;
               rsp_word_in.status  = res_s_ff;
               ncount_in           = '0;
               nov_in              = 1'b0;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pcount_ff     <= '0;
         pov_ff        <= 1'b0;
         pclosed_ff    <= 1'b0;
         cap_ff        <= 1'b0;
         meta_ff       <= 1'b0;
         lstar_ff      <= '0;
         sstar_ff      <= 1'b0;
         smeta_ff      <= 1'b0;
         ncount_ff     <= '0;
         nov_ff        <= 1'b0;
         fold_mode_ff  <= gosm_pkg::FOLD_NEVER;
         whole_ff      <= 1'b0;
         fold_ff       <= 1'b0;
         substr_ff     <= 1'b0;
         have_star_ff  <= 1'b0;
         pi_ff         <= '0;
         star_next_ff  <= '0;
         q_ff          <= '0;
         ni_ff         <= '0;
         retry_ff      <= '0;
         neg_ff        <= 1'b0;
         ok_ff         <= 1'b0;
         res_m_ff      <= 1'b0;
         res_s_ff      <= gosm_pkg::STATUS_OK;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pcount_ff     <= pcount_in;
         pov_ff        <= pov_in;
         pclosed_ff    <= pclosed_in;
         cap_ff        <= cap_in;
         meta_ff       <= meta_in;
         lstar_ff      <= lstar_in;
         sstar_ff      <= sstar_in;
         smeta_ff      <= smeta_in;
         ncount_ff     <= ncount_in;
         nov_ff        <= nov_in;
         fold_mode_ff  <= fold_mode_in;
         whole_ff      <= whole_in;
         fold_ff       <= fold_in;
         substr_ff     <= substr_in;
         have_star_ff  <= have_star_in;
         pi_ff         <= pi_in;
         star_next_ff  <= star_next_in;
         q_ff          <= q_in;
         ni_ff         <= ni_in;
         retry_ff      <= retry_in;
         neg_ff        <= neg_in;
         ok_ff         <= ok_in;
         res_m_ff      <= res_m_in;
         res_s_ff      <= res_s_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload holding registers
   always_ff @(posedge clock) begin
      nb_ff       <= nb_in;
      b0_ff       <= b0_in;
      b1_ff       <= b1_in;
      rsp_word_ff <= rsp_word_in;
   end

   // Pattern memory
   always_ff @(posedge clock) begin
      if (p_we) begin
         pmem[p_waddr] <= req_word.char_byte;
      end
      p_rd_ff <= pmem[p_raddr];
   end

   // Name memory
   always_ff @(posedge clock) begin
      if (n_we) begin
         nmem[n_waddr] <= req_word.char_byte;
      end
      n_rd_ff <= nmem[n_raddr];
   end

   `GOSM_ASSERT_NEXT(a_close_starts, clock, reset,
      req_acc && req_word.action && close, state_ff == ST_START)
   `GOSM_ASSERT_NOW(a_pi_bound, clock, reset,
      state_ff == ST_STEP, pi_ff <= pcount_ff)
   `GOSM_ASSERT_NOW(a_ni_bound, clock, reset,
      state_ff == ST_STEP, ni_ff <= ncount_ff)
   `GOSM_ASSERT_NEXT(a_done_delivers, clock, reset,
      state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall),
      rsp_valid_ff && state_ff == ST_IDLE)

endmodule

### tb/sv/glob_or_substring_name_matcher_tb.sv
`timescale 1ns / 1ps

module glob_or_substring_name_matcher_tb;

   localparam int PAT_MAX  = 64;
   localparam int NAME_MAX = 256;
   localparam int IDLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1000;
   localparam logic [1:0] CASE_SMART     = 2'd2;
   localparam logic [1:0] CASE_SMART_ALT = 2'd3;
   localparam logic ACT_PATTERN = 1'b0;
   localparam logic ACT_NAME    = 1'b1;

   // Mirror of the matcher state; predicts one verdict per closed name
   class match_board;
      logic [7:0] pat[PAT_MAX];
      logic [7:0] nam[NAME_MAX];
      int pcount, ncount;
      bit pover, pclosed, nover;
      logic [1:0] fold_mode;
      bit whole_name;
      bit fold_on;
      gosm_pkg::rsp_word_type verdicts[$];
      int errors;

      function void set_reg(logic idx, logic [1:0] value);
         if (idx == gosm_pkg::CSR_FOLD_MODE) fold_mode = value;
         else whole_name = value[0];
      endfunction

      function logic [7:0] fold(logic [7:0] c);
         if (fold_on && c >= gosm_pkg::UPPER_A && c <= gosm_pkg::UPPER_Z)
            return c + gosm_pkg::FOLD_DELTA;
         return c;
      endfunction

      function bit meta_byte(logic [7:0] c);
         return c == gosm_pkg::STAR || c == gosm_pkg::QMARK || c == gosm_pkg::LBRACK;
      endfunction

      // Scan a bracket class starting just after '['
      function bit class_hit(int q, output int endp, input logic [7:0] c);
         bit neg, ok;
         logic [7:0] fc;
         neg = 0;
         ok = 0;
         fc = fold(c);
         if (q < pcount && pat[q] == gosm_pkg::BANG) begin
            neg = 1;
            q++;
         end
         while (q < pcount && pat[q] != gosm_pkg::RBRACK) begin
            if (q + 2 < pcount && pat[q+1] == gosm_pkg::DASH
                && pat[q+2] != gosm_pkg::RBRACK) begin
               if (fc >= fold(pat[q]) && fc <= fold(pat[q+2])) ok = 1;
               q += 3;
            end else begin
               if (fc == fold(pat[q])) ok = 1;
               q++;
            end
         end
         if (q < pcount && pat[q] == gosm_pkg::RBRACK) q++;
         endp = q;
         return neg ? !ok : ok;
      endfunction

      // Whole-name glob with backtracking to the latest star
      function bit glob_walk();
         int pi, ni, star, retry, endp;
         bit have_star;
         logic [7:0] pc;
         pi = 0; ni = 0; star = 0; retry = 0;
         have_star = 0;
         while (ni < ncount) begin
            pc = pi < pcount ? pat[pi] : 8'h00;
            if (pi < pcount && pc == gosm_pkg::QMARK) begin
               pi++; ni++;
            end else if (pi < pcount && pc == gosm_pkg::LBRACK
                         && class_hit(pi + 1, endp, nam[ni])) begin
               pi = endp; ni++;
            end else if (pi < pcount && pc != gosm_pkg::STAR && pc != gosm_pkg::LBRACK
                         && fold(pc) == fold(nam[ni])) begin
               pi++; ni++;
            end else if (pi < pcount && pc == gosm_pkg::STAR) begin
               star = pi; have_star = 1; pi++; retry = ni;
            end else if (have_star) begin
               pi = star + 1; retry++; ni = retry;
            end else begin
               return 0;
            end
         end
         while (pi < pcount && pat[pi] == gosm_pkg::STAR) pi++;
         return pi == pcount;
      endfunction

      function bit name_matches();
         int i, h, pfxl, star_pos, s, sl;
         bit meta, have_star, sfx_meta;
         if (pcount == 0) return 1;
         meta = 0; have_star = 0; pfxl = pcount; star_pos = 0;
         for (i = 0; i < pcount; i++) begin
            if (meta_byte(pat[i])) begin
               if (!meta) pfxl = i;
               meta = 1;
            end
            if (pat[i] == gosm_pkg::STAR) begin
               star_pos = i;
               have_star = 1;
            end
         end
         // Smart case folds unless the pattern holds a capital
         if (fold_mode == gosm_pkg::FOLD_NEVER) fold_on = 0;
         else if (fold_mode == gosm_pkg::FOLD_ALWAYS) fold_on = 1;
         else begin
            fold_on = 1;
            for (i = 0; i < pcount; i++)
               if (pat[i] >= gosm_pkg::UPPER_A && pat[i] <= gosm_pkg::UPPER_Z) fold_on = 0;
         end
         // Plain word: substring search, or exact compare when forced
         if (!meta) begin
            if (ncount < pcount) return 0;
            if (!whole_name) begin
               for (h = 0; h + pcount <= ncount; h++) begin
                  for (i = 0; i < pcount; i++)
                     if (fold(nam[h+i]) != fold(pat[i])) break;
                  if (i == pcount) return 1;
               end
               return 0;
            end
            for (i = 0; i < pcount; i++)
               if (fold(nam[i]) != fold(pat[i])) return 0;
            return ncount == pcount;
         end
         // Literal prefix and suffix shortcuts
         if (ncount < pfxl) return 0;
         for (i = 0; i < pfxl; i++)
            if (fold(nam[i]) != fold(pat[i])) return 0;
         if (have_star && star_pos + 1 < pcount) begin
            s = star_pos + 1;
            sl = pcount - s;
            sfx_meta = 0;
            for (i = s; i < pcount; i++)
               if (meta_byte(pat[i])) sfx_meta = 1;
            if (!sfx_meta) begin
               if (ncount < sl) return 0;
               for (i = 0; i < sl; i++)
                  if (fold(nam[ncount-sl+i]) != fold(pat[s+i])) return 0;
            end
         end
         return glob_walk();
      endfunction

      function void note_word(gosm_pkg::req_word_type w);
         gosm_pkg::rsp_word_type v;
         bit close;
         close = w.last || w.empty_req;
         if (w.action == ACT_PATTERN) begin
            if (pclosed) begin
               pcount = 0; pover = 0; pclosed = 0;
            end
            if (!w.empty_req) begin
               if (pcount < PAT_MAX) pat[pcount++] = w.char_byte;
               else pover = 1;
            end
            if (close) pclosed = 1;
         end else begin
            if (!w.empty_req) begin
               if (ncount < NAME_MAX) nam[ncount++] = w.char_byte;
               else nover = 1;
            end
            if (close) begin
               if (pover) v = '{matched: 1'b0, status: gosm_pkg::STATUS_PAT_BIG};
               else if (nover) v = '{matched: 1'b0, status: gosm_pkg::STATUS_NAME_BIG};
               else v = '{matched: name_matches(), status: gosm_pkg::STATUS_OK};
               verdicts.push_back(v);
               ncount = 0;
               nover = 0;
            end
         end
      endfunction

      function void check_word(gosm_pkg::rsp_word_type got);
         gosm_pkg::rsp_word_type exp_w;
         if (verdicts.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected rsp word matched=%0b status=%0d",
                                       got.matched, got.status);
         end else begin
            exp_w = verdicts.pop_front();
            if (got.matched !== exp_w.matched || got.status !== exp_w.status) begin
               errors++;
               if (errors <= 10)
                  $display("rsp mismatch: expected matched=%0b status=%0d, got %0b %0d",
                           exp_w.matched, exp_w.status, got.matched, got.status);
            end
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   gosm_pkg::req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   gosm_pkg::rsp_word_type rsp_word;
   logic csr_valid = 0;
   logic csr_ready;
   logic csr_index = 0;
   logic [1:0] csr_wdata = '0;

   match_board board = new();
   bit quiet = 0;
   int idle_cycles = 0;
   int rsp_hold = 0;
   int sent = 0;

   glob_or_substring_name_matcher DUT (.*);

   always #6 clock = ~clock;

   // Track accepted words and watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_word(req_word);
         if (rsp_valid && !rsp_stall) board.check_word(rsp_word);
         if (csr_valid && csr_ready) board.set_reg(csr_index, csr_wdata);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // Result-side backpressure in random bursts
   always @(negedge clock) begin
      if (rsp_hold > 0) rsp_hold--;
      else begin
         rsp_hold = gap_len();
         rsp_stall <= (rsp_hold > 0) && !reset;
      end
   end

   task automatic send_word(logic act, logic [7:0] b, logic lst, logic emp);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1;
      req_word <= '{action: act, char_byte: b, last: lst, empty_req: emp};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent++;
   endtask

   // Send a whole string; an empty one or a late close uses an empty word
   task automatic send_str(logic act, logic [7:0] s[$], bit close_empty);
      int i;
      for (i = 0; i < s.size(); i++)
         send_word(act, s[i], (i == s.size() - 1) && !close_empty, 1'b0);
      if (s.size() == 0 || close_empty)
         send_word(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
   endtask

   function automatic void to_bytes(string t, ref logic [7:0] s[$]);
      s = {};
      foreach (t[i]) s.push_back(t[i]);
   endfunction

   task automatic send_text(logic act, string t);
      logic [7:0] s[$];
      to_bytes(t, s);
      send_str(act, s, 1'b0);
   endtask

   task automatic write_reg(logic idx, logic [1:0] value);
      req_valid <= 0;
      while (board.verdicts.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic [7:0] pat_byte();
      string alpha;
      alpha = "ab?*[]!-zA";
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return alpha[$urandom_range(0, alpha.len() - 1)];
   endfunction

   function automatic logic [7:0] name_byte();
      string alpha;
      alpha = "abAB-z";
      if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
      return alpha[$urandom_range(0, alpha.len() - 1)];
   endfunction

   task automatic random_phase(int count);
      logic [7:0] s[$];
      int stop, n, len, k;
      stop = sent + count;
      while (sent < stop) begin
         if ($urandom_range(0, 99) < 85) begin
            // Well-formed pattern followed by a few names
            len = $urandom_range(0, 19) == 0 ? $urandom_range(60, 68) : $urandom_range(0, 7);
            s = {};
            repeat (len) s.push_back(pat_byte());
            send_str(ACT_PATTERN, s, $urandom_range(0, 4) == 0);
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) begin
               len = $urandom_range(0, 49) == 0 ? $urandom_range(250, 260)
                                                : $urandom_range(0, 10);
               s = {};
               repeat (len) s.push_back(name_byte());
               send_str(ACT_NAME, s, $urandom_range(0, 4) == 0);
            end
         end else begin
            send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0);
         end
      end
   endtask

   initial begin
      logic [7:0] s[$];
      int i;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: empty pattern, substring, globs and classes
      send_str(ACT_PATTERN, s, 1'b0);
      send_text(ACT_NAME, "anything");
      send_text(ACT_PATTERN, "ab");
      send_text(ACT_NAME, "xaby");
      send_text(ACT_PATTERN, "a*b?c[!x-z]");
      send_text(ACT_NAME, "aqqbxcd");
      send_text(ACT_PATTERN, "[a-c");
      send_text(ACT_NAME, "b");
      // Star inside a class ahead of a literal tail
      send_text(ACT_PATTERN, "[*]ab");
      send_text(ACT_NAME, "*ab");
      // Zero byte, and a name while the pattern is still open
      send_word(ACT_PATTERN, 8'h00, 1'b0, 1'b0);
      send_word(ACT_NAME, 8'h00, 1'b1, 1'b0);
      send_word(ACT_PATTERN, 8'hFF, 1'b1, 1'b0);
      // Pattern bytes while a name is open
      send_word(ACT_NAME, 8'hFF, 1'b0, 1'b0);
      send_text(ACT_PATTERN, "?");
      send_word(ACT_NAME, 8'h00, 1'b0, 1'b1);
      // Too long pattern, then too long name
      s = {};
      for (i = 0; i < PAT_MAX + 2; i++) s.push_back(8'h61);
      send_str(ACT_PATTERN, s, 1'b0);
      send_text(ACT_NAME, "a");
      send_text(ACT_PATTERN, "*");
      s = {};
      for (i = 0; i < NAME_MAX + 2; i++) s.push_back(8'h62);
      send_str(ACT_NAME, s, 1'b1);
      // Case modes and forced exact compare
      write_reg(gosm_pkg::CSR_WHOLE_NAME, 2'd1);
      write_reg(gosm_pkg::CSR_FOLD_MODE, CASE_SMART);
      send_text(ACT_PATTERN, "Ab");
      send_text(ACT_NAME, "ab");
      send_text(ACT_PATTERN, "ab");
      send_text(ACT_NAME, "AB");

      // Random phases over several register settings, one without idling
      write_reg(gosm_pkg::CSR_FOLD_MODE, gosm_pkg::FOLD_NEVER);
      write_reg(gosm_pkg::CSR_WHOLE_NAME, 2'd0);
      random_phase(RANDOM_ITEMS / 5);
      write_reg(gosm_pkg::CSR_FOLD_MODE, gosm_pkg::FOLD_ALWAYS);
      write_reg(gosm_pkg::CSR_WHOLE_NAME, 2'd1);
      quiet = 1;
      random_phase(RANDOM_ITEMS / 5);
      quiet = 0;
      write_reg(gosm_pkg::CSR_FOLD_MODE, CASE_SMART);
      random_phase(RANDOM_ITEMS / 5);
      write_reg(gosm_pkg::CSR_FOLD_MODE, CASE_SMART_ALT);
      write_reg(gosm_pkg::CSR_WHOLE_NAME, 2'd0);
      random_phase(RANDOM_ITEMS / 5);
      write_reg(gosm_pkg::CSR_FOLD_MODE, gosm_pkg::FOLD_ALWAYS);
      random_phase(RANDOM_ITEMS / 5);

      // Drain
      req_valid <= 0;
      while (board.verdicts.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (board.errors == 0 && board.verdicts.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
